FILE: rtl/ldlr_pkg.sv
`default_nettype none

package ldlr_pkg;

  // Store geometry
  localparam int unsigned DEPTH  = 8192;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned FILL_W = 13;

  // Action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_REWIND = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef logic [AW-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_DONE
  } state_e;

  // Store access request from the sequencer
  typedef struct packed {
    logic       we;
    idx_t       waddr;
    logic [7:0] wdata;
    logic       re;
    idx_t       raddr;
  } mem_req_t;

  // One finished result
  typedef struct packed {
    logic [7:0]        rbyte;
    logic              rvalid;
    logic              rlast;
    logic [FILL_W-1:0] fill;
    logic              dropped;
  } result_t;

  // Ring index advance with wrap
  function automatic idx_t next_idx(input idx_t i);
    idx_t n;
    if (i == idx_t'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + idx_t'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ldlr_ram.sv
`default_nettype none

module ldlr_ram (
  input  wire logic               clk_i,
  input  wire ldlr_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);

  logic [7:0] mem [ldlr_pkg::DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ldlr_seq.sv
`default_nettype none

module ldlr_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [7:0]         data_byte_i,
  output ldlr_pkg::mem_req_t      mem_req_o,
  input  wire logic [7:0]         mem_rdata_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output ldlr_pkg::result_t       res_o
);

  ldlr_pkg::state_e st_q, st_d;
  ldlr_pkg::idx_t   head_q, head_d;
  ldlr_pkg::idx_t   tail_q, tail_d;
  ldlr_pkg::idx_t   cur_q, cur_d;
  logic             hit_q, hit_d;
  logic             last_q, last_d;
  logic             drop_q, drop_d;

  logic             in_fire;
  logic             cur_has_data;
  logic             walk_stop;
  ldlr_pkg::idx_t   inc_op;
  ldlr_pkg::idx_t   inc_res;
  logic [ldlr_pkg::AW:0] diff;

  assign in_ready_o   = (st_q == ldlr_pkg::ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign cur_has_data = (cur_q != head_q);
  assign walk_stop    = (mem_rdata_i == ldlr_pkg::NEWLINE) || (tail_q == head_q);

  // Shared index incrementer: head on write, cursor on read, tail while dropping
  always_comb begin
    if (st_q == ldlr_pkg::ST_IDLE) begin
      inc_op = (action_i == ldlr_pkg::ACT_READ) ? cur_q : head_q;
    end else begin
      inc_op = tail_q;
    end
  end
  assign inc_res = ldlr_pkg::next_idx(inc_op);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ldlr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (action_i == ldlr_pkg::ACT_WRITE && inc_res == tail_q) begin
            st_d = ldlr_pkg::ST_DROP_RD;
          end else begin
            st_d = ldlr_pkg::ST_DONE;
          end
        end
      end
      ldlr_pkg::ST_DROP_RD: st_d = ldlr_pkg::ST_DROP_CHK;
      ldlr_pkg::ST_DROP_CHK: begin
        if (walk_stop) begin
          st_d = ldlr_pkg::ST_DONE;
        end
      end
      ldlr_pkg::ST_DONE: begin
        if (res_ready_i) begin
          st_d = ldlr_pkg::ST_IDLE;
        end
      end
      default: st_d = ldlr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and store requests
  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    cur_d           = cur_q;
    hit_d           = hit_q;
    last_d          = last_q;
    drop_d          = drop_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = head_q;
    mem_req_o.wdata = data_byte_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = (st_q == ldlr_pkg::ST_IDLE) ? cur_q : tail_q;
    case (st_q)
      ldlr_pkg::ST_IDLE: begin
        if (in_fire) begin
          hit_d  = 1'b0;
          last_d = 1'b0;
          drop_d = 1'b0;
          case (action_i)
            ldlr_pkg::ACT_WRITE: begin
              mem_req_o.we = 1'b1;
              head_d       = inc_res;
              drop_d       = (inc_res == tail_q);
            end
            ldlr_pkg::ACT_REWIND: cur_d = tail_q;
            ldlr_pkg::ACT_READ: begin
              if (cur_has_data) begin
                mem_req_o.re = 1'b1;
                cur_d        = inc_res;
                hit_d        = 1'b1;
                last_d       = (inc_res == head_q);
              end
            end
            default: ;
          endcase
        end
      end
      ldlr_pkg::ST_DROP_RD: begin
        mem_req_o.re = 1'b1;
        tail_d       = inc_res;
      end
      ldlr_pkg::ST_DROP_CHK: begin
        if (walk_stop) begin
          cur_d = tail_q;
        end else begin
          mem_req_o.re = 1'b1;
          tail_d       = inc_res;
        end
      end
      default: ;
    endcase
  end

  // Fill level from the ring pointers
  always_comb begin
    diff = {1'b0, head_q} - {1'b0, tail_q};
    if (head_q < tail_q) begin
      diff = diff + (ldlr_pkg::AW + 1)'(ldlr_pkg::DEPTH);
    end
  end

  assign res_valid_o   = (st_q == ldlr_pkg::ST_DONE);
  assign res_o.rbyte   = hit_q ? mem_rdata_i : 8'd0;
  assign res_o.rvalid  = hit_q;
  assign res_o.rlast   = last_q;
  assign res_o.fill    = ldlr_pkg::FILL_W'(diff);
  assign res_o.dropped = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ldlr_pkg::ST_IDLE;
      head_q <= '0;
      tail_q <= '0;
      cur_q  <= '0;
      hit_q  <= 1'b0;
      last_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cur_q  <= cur_d;
      hit_q  <= hit_d;
      last_q <= last_d;
      drop_q <= drop_d;
    end
  end

  // A write always moves the head
  a_write_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && action_i == ldlr_pkg::ACT_WRITE |=> head_q != $past(head_q))
    else $error("head did not advance on write");

  // Rewind lands the cursor on the tail
  a_rewind_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && action_i == ldlr_pkg::ACT_REWIND |=> cur_q == tail_q)
    else $error("cursor not at tail after rewind");

  // End of a drop walk parks the cursor on the new tail
  a_drop_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ldlr_pkg::ST_DROP_CHK && walk_stop |=> cur_q == tail_q && drop_q)
    else $error("cursor not at tail after drop");

  // Head is frozen outside the accept cycle
  a_head_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ldlr_pkg::ST_IDLE |=> $stable(head_q))
    else $error("head moved while busy");

endmodule

`default_nettype wire

FILE: rtl/line_dropping_log_ring.sv
// Flow: an accepted write, read or rewind passes through the DONE state and then the
//   output register; a write into a full ring first walks the oldest line through
//   DROP_RD and DROP_CHK, one store read per cycle, until a newline or an empty ring.
// Items: no new item is taken until the last result leaves DONE; the single store port sets the walk rate.
// Reset: rst_ni async low; pointers zero, ring empty, store contents not cleared.
`default_nettype none

module line_dropping_log_ring (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] read_byte, [20:8] fill_level, [21] dropped
  output logic             m_axis_tlast,   // read_last
  output logic [0:0]       m_axis_tuser    // [0] read_valid
);

  ldlr_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  logic               res_valid;
  logic               res_ready;
  ldlr_pkg::result_t  res;
  ldlr_pkg::result_t  out_q;
  logic               out_vld_q;

  ldlr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ldlr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.dropped, out_q.fill, out_q.rbyte};
  assign m_axis_tlast  = out_q.rlast;
  assign m_axis_tuser  = out_q.rvalid;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ldlr_pkg::*;

  // Code the block has no use for; it must change nothing
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Expected log ring state and the results owed by the block
  class log_ring_board;
    logic [7:0]  ring [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned cursor;
    int unsigned mismatches;
    result_t     owed_results [$];

    function new();
      head       = 0;
      tail       = 0;
      cursor     = 0;
      mismatches = 0;
    endfunction

    function int unsigned held();
      return (head + DEPTH - tail) % DEPTH;
    endfunction

    function int unsigned leftover();
      return owed_results.size();
    endfunction

    // Advance the ring by one accepted action and queue the result it owes
    function void apply_action(logic [1:0] act, logic [7:0] b);
      result_t    r;
      logic [7:0] ch;
      r = '0;
      case (act)
        ACT_WRITE: begin
          ring[head] = b;
          head = (head + 1) % DEPTH;
          // full: drop the oldest line, or everything when no newline is held
          if (head == tail) begin
            r.dropped = 1'b1;
            ch = ring[tail];
            tail = (tail + 1) % DEPTH;
            while (ch != NEWLINE && tail != head) begin
              ch = ring[tail];
              tail = (tail + 1) % DEPTH;
            end
            cursor = tail;
          end
        end
        ACT_REWIND: begin
          cursor = tail;
        end
        ACT_READ: begin
          // cursor at head: nothing left, cursor stays
          if (cursor != head) begin
            r.rbyte  = ring[cursor];
            r.rvalid = 1'b1;
            cursor   = (cursor + 1) % DEPTH;
            r.rlast  = (cursor == head);
          end
        end
        default: begin
        end
      endcase
      r.fill = FILL_W'(held());
      owed_results.push_back(r);
    endfunction

    // Compare one output transfer with the oldest owed result
    function void match_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with none owed: byte %h valid %b last %b fill %0d drop %b",
                   $time, got.rbyte, got.rvalid, got.rlast, got.fill, got.dropped);
        end
        return;
      end
      want = owed_results.pop_front();
      if (got.rbyte !== want.rbyte || got.rvalid !== want.rvalid ||
          got.rlast !== want.rlast || got.fill !== want.fill ||
          got.dropped !== want.dropped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected byte %h valid %b last %b fill %0d drop %b", $time,
                   want.rbyte, want.rvalid, want.rlast, want.fill, want.dropped);
          $display("%0t: got      byte %h valid %b last %b fill %0d drop %b", $time,
                   got.rbyte, got.rvalid, got.rlast, got.fill, got.dropped);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] read_byte, [20:8] fill_level, [21] dropped
  logic        m_axis_tlast;         // read_last
  logic [0:0]  m_axis_tuser;         // [0] read_valid

  bit            idle_on = 1'b1;
  int unsigned   counted = 0;
  log_ring_board board   = new();

  line_dropping_log_ring dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Any byte but a newline
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NEWLINE) begin
      b = 8'h8A;
    end
    return b;
  endfunction

  // Mostly short log lines, now and then a long one
  function automatic int unsigned line_length();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(25, 300);
    end
    return $urandom_range(0, 24);
  endfunction

  // One input transfer, with an optional idle burst ahead of it
  task automatic issue_action(input logic [1:0] act, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.apply_action(act, b);
    if (act != ACT_NONE) begin
      counted++;
    end
  endtask

  task automatic write_line(input int unsigned len, input bit ended);
    repeat (len) issue_action(ACT_WRITE, plain_byte());
    if (ended) begin
      issue_action(ACT_WRITE, NEWLINE);
    end
  endtask

  // Output side: check each transfer, stall in random bursts
  initial begin : sink
    int unsigned stall;
    result_t     got;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.rbyte   = m_axis_tdata[7:0];
        got.fill    = m_axis_tdata[20:8];
        got.dropped = m_axis_tdata[21];
        got.rlast   = m_axis_tlast;
        got.rvalid  = m_axis_tuser[0];
        board.match_result(got);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring: read with nothing held, unused code, rewind
    issue_action(ACT_READ, 8'hFF);
    issue_action(ACT_NONE, 8'hA5);
    issue_action(ACT_REWIND, 8'h00);
    // short line with extreme bytes, read back through its end and past it
    issue_action(ACT_WRITE, 8'h00);
    issue_action(ACT_WRITE, 8'hFF);
    issue_action(ACT_WRITE, NEWLINE);
    issue_action(ACT_WRITE, 8'h7F);
    issue_action(ACT_READ, 8'h00);
    issue_action(ACT_READ, 8'hFF);
    issue_action(ACT_REWIND, 8'hFF);
    repeat (5) issue_action(ACT_READ, 8'h55);
    issue_action(ACT_NONE, 8'h5A);

    // random mix: log lines, reads, rewinds, unused codes
    counted = 0;
    while (counted < 520) begin
      if (counted >= 420) begin
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        write_line(line_length(), $urandom_range(0, 7) != 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 12)) issue_action(ACT_READ, 8'($urandom()));
      end else if (pick < 88) begin
        issue_action(ACT_REWIND, 8'($urandom()));
      end else if (pick < 93) begin
        issue_action(ACT_NONE, 8'($urandom()));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          issue_action(ACT_WRITE, 8'($urandom()));
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray transfers
    while (board.leftover() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.leftover() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(10_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule
